// ===== rtl/core/gak_pkg.sv =====
// Shared types, constants and helpers for the gyro/accelerometer angle Kalman filter.
// Holds the microcode table, the saturating arithmetic and the fixed-point multiply.
// Depends on nothing; every other file imports it.
package gak_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC   = 30;
    localparam int CFG_W  = 31;
    localparam int CIDX_W = 3;
    localparam int ADDR_W = 4;
    localparam int MEM_D  = 1 << ADDR_W;
    localparam int PC_W   = 6;
    localparam int OP_W   = 3;
    localparam int SA_W   = 3;
    localparam int SB_W   = 2;
    localparam int Q_W    = WORD_W - 1;
    localparam int CNT_W  = $clog2(Q_W);
    localparam int PROD_W = 2 * WORD_W;
    localparam int SHR_W  = PROD_W - FRAC;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [WORD_W-1:0] W_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] W_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ONE_Q  = WORD_W'(64'd1 << FRAC);
    localparam logic [Q_W-1:0]    GAIN_MAX = {Q_W{1'b1}};

    // Configuration register indexes and reset values.
    localparam logic [CIDX_W-1:0] CFG_QA = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_QB = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_RN = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] CFG_DT = CIDX_W'(3);
    localparam logic [CFG_W-1:0]  QA_RST = CFG_W'(1073742);
    localparam logic [CFG_W-1:0]  QB_RST = CFG_W'(3221225);
    localparam logic [CFG_W-1:0]  RN_RST = CFG_W'(536870912);
    localparam logic [CFG_W-1:0]  DT_RST = CFG_W'(1073742);

    // Micro-operations.
    localparam logic [OP_W-1:0] OP_ADD = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SUB = OP_W'(1);
    localparam logic [OP_W-1:0] OP_MUL = OP_W'(2);
    localparam logic [OP_W-1:0] OP_DIV = OP_W'(3);
    localparam logic [OP_W-1:0] OP_OUT = OP_W'(4);
    localparam logic [OP_W-1:0] OP_END = OP_W'(5);

    // Operand A sources.
    localparam logic [SA_W-1:0] SA_MEM  = SA_W'(0);
    localparam logic [SA_W-1:0] SA_GYRO = SA_W'(1);
    localparam logic [SA_W-1:0] SA_MEAS = SA_W'(2);
    localparam logic [SA_W-1:0] SA_QA   = SA_W'(3);
    localparam logic [SA_W-1:0] SA_QB   = SA_W'(4);
    localparam logic [SA_W-1:0] SA_RN   = SA_W'(5);
    localparam logic [SA_W-1:0] SA_ZERO = SA_W'(6);
    localparam logic [SA_W-1:0] SA_ONE  = SA_W'(7);

    // Operand B sources.
    localparam logic [SB_W-1:0] SB_MEM  = SB_W'(0);
    localparam logic [SB_W-1:0] SB_DT   = SB_W'(1);
    localparam logic [SB_W-1:0] SB_ZERO = SB_W'(2);

    // Scratch memory map.
    localparam logic [ADDR_W-1:0] A_ANG  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] A_BIAS = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] A_PAA  = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] A_PAB  = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] A_PBA  = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] A_PBB  = ADDR_W'(5);
    localparam logic [ADDR_W-1:0] A_X    = ADDR_W'(6);
    localparam logic [ADDR_W-1:0] A_M    = ADDR_W'(7);
    localparam logic [ADDR_W-1:0] A_D    = ADDR_W'(8);
    localparam logic [ADDR_W-1:0] A_ERR  = ADDR_W'(9);
    localparam logic [ADDR_W-1:0] A_E    = ADDR_W'(10);
    localparam logic [ADDR_W-1:0] A_K0   = ADDR_W'(11);
    localparam logic [ADDR_W-1:0] A_K1   = ADDR_W'(12);

    localparam logic [PC_W-1:0] PC_INIT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_ITEM = PC_W'(7);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SA_W-1:0]   src_a;
        logic [SB_W-1:0]   src_b;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [ADDR_W-1:0] dst;
    } uword_t;

    typedef struct packed {
        uword_t word;
        logic   ph_read;
        logic   ph_exec;
        logic   ph_wb;
        logic   ph_wait;
        logic   accept;
    } seq_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [CFG_W-1:0] qa;
        logic [CFG_W-1:0] qb;
        logic [CFG_W-1:0] rn;
        logic [CFG_W-1:0] dt;
    } cfg_t;

    function automatic uword_t uw(input logic [OP_W-1:0] op, input logic [SA_W-1:0] sa,
                                  input logic [SB_W-1:0] sb, input logic [ADDR_W-1:0] aa,
                                  input logic [ADDR_W-1:0] ab, input logic [ADDR_W-1:0] d);
        uword_t w;
        w.op     = op;
        w.src_a  = sa;
        w.src_b  = sb;
        w.addr_a = aa;
        w.addr_b = ab;
        w.dst    = d;
        return w;
    endfunction

    // Microcode. The first block initialises the filter state after reset; the second runs
    // one predict and correct pass for an item and presents the result.
    function automatic uword_t rom_word(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_W'(0):  w = uw(OP_ADD, SA_ZERO, SB_ZERO, A_ANG, A_ANG, A_ANG);
            PC_W'(1):  w = uw(OP_ADD, SA_ZERO, SB_ZERO, A_ANG, A_ANG, A_BIAS);
            PC_W'(2):  w = uw(OP_ADD, SA_ONE,  SB_ZERO, A_ANG, A_ANG, A_PAA);
            PC_W'(3):  w = uw(OP_ADD, SA_ZERO, SB_ZERO, A_ANG, A_ANG, A_PAB);
            PC_W'(4):  w = uw(OP_ADD, SA_ZERO, SB_ZERO, A_ANG, A_ANG, A_PBA);
            PC_W'(5):  w = uw(OP_ADD, SA_ONE,  SB_ZERO, A_ANG, A_ANG, A_PBB);
            PC_W'(6):  w = uw(OP_END, SA_ZERO, SB_ZERO, A_ANG, A_ANG, A_ANG);
            // Predict the angle.
            PC_W'(7):  w = uw(OP_SUB, SA_GYRO, SB_MEM,  A_ANG, A_BIAS, A_X);
            PC_W'(8):  w = uw(OP_MUL, SA_MEM,  SB_DT,   A_X,   A_ANG,  A_M);
            PC_W'(9):  w = uw(OP_ADD, SA_MEM,  SB_MEM,  A_ANG, A_M,    A_ANG);
            // Integrate the covariance derivative.
            PC_W'(10): w = uw(OP_SUB, SA_QA,   SB_MEM,  A_ANG, A_PAB,  A_D);
            PC_W'(11): w = uw(OP_SUB, SA_MEM,  SB_MEM,  A_D,   A_PBA,  A_D);
            PC_W'(12): w = uw(OP_MUL, SA_MEM,  SB_DT,   A_D,   A_ANG,  A_M);
            PC_W'(13): w = uw(OP_ADD, SA_MEM,  SB_MEM,  A_PAA, A_M,    A_PAA);
            PC_W'(14): w = uw(OP_SUB, SA_ZERO, SB_MEM,  A_ANG, A_PBB,  A_D);
            PC_W'(15): w = uw(OP_MUL, SA_MEM,  SB_DT,   A_D,   A_ANG,  A_M);
            PC_W'(16): w = uw(OP_ADD, SA_MEM,  SB_MEM,  A_PAB, A_M,    A_PAB);
            PC_W'(17): w = uw(OP_ADD, SA_MEM,  SB_MEM,  A_PBA, A_M,    A_PBA);
            PC_W'(18): w = uw(OP_MUL, SA_QB,   SB_DT,   A_ANG, A_ANG,  A_M);
            PC_W'(19): w = uw(OP_ADD, SA_MEM,  SB_MEM,  A_PBB, A_M,    A_PBB);
            // Innovation and gains.
            PC_W'(20): w = uw(OP_SUB, SA_MEAS, SB_MEM,  A_ANG, A_ANG,  A_ERR);
            PC_W'(21): w = uw(OP_ADD, SA_RN,   SB_MEM,  A_ANG, A_PAA,  A_E);
            PC_W'(22): w = uw(OP_DIV, SA_MEM,  SB_MEM,  A_PAA, A_E,    A_K0);
            PC_W'(23): w = uw(OP_DIV, SA_MEM,  SB_MEM,  A_PBA, A_E,    A_K1);
            // Correct the covariance; the lower row goes first so it sees the old upper row.
            PC_W'(24): w = uw(OP_MUL, SA_MEM,  SB_MEM,  A_K1,  A_PAA,  A_M);
            PC_W'(25): w = uw(OP_SUB, SA_MEM,  SB_MEM,  A_PBA, A_M,    A_PBA);
            PC_W'(26): w = uw(OP_MUL, SA_MEM,  SB_MEM,  A_K1,  A_PAB,  A_M);
            PC_W'(27): w = uw(OP_SUB, SA_MEM,  SB_MEM,  A_PBB, A_M,    A_PBB);
            PC_W'(28): w = uw(OP_MUL, SA_MEM,  SB_MEM,  A_K0,  A_PAA,  A_M);
            PC_W'(29): w = uw(OP_SUB, SA_MEM,  SB_MEM,  A_PAA, A_M,    A_PAA);
            PC_W'(30): w = uw(OP_MUL, SA_MEM,  SB_MEM,  A_K0,  A_PAB,  A_M);
            PC_W'(31): w = uw(OP_SUB, SA_MEM,  SB_MEM,  A_PAB, A_M,    A_PAB);
            // Correct the angle and the bias.
            PC_W'(32): w = uw(OP_MUL, SA_MEM,  SB_MEM,  A_K0,  A_ERR,  A_M);
            PC_W'(33): w = uw(OP_ADD, SA_MEM,  SB_MEM,  A_ANG, A_M,    A_ANG);
            PC_W'(34): w = uw(OP_MUL, SA_MEM,  SB_MEM,  A_K1,  A_ERR,  A_M);
            PC_W'(35): w = uw(OP_ADD, SA_MEM,  SB_MEM,  A_BIAS, A_M,   A_BIAS);
            // Result.
            PC_W'(36): w = uw(OP_SUB, SA_GYRO, SB_MEM,  A_ANG, A_BIAS, A_X);
            PC_W'(37): w = uw(OP_OUT, SA_MEM,  SB_MEM,  A_ANG, A_X,    A_ANG);
            default:   w = uw(OP_END, SA_ZERO, SB_ZERO, A_ANG, A_ANG,  A_ANG);
        endcase
        return w;
    endfunction

    // Saturating add or subtract on one word.
    function automatic word_t sat_addsub(input word_t a, input word_t b, input logic sub);
        logic signed [WORD_W:0] ea;
        logic signed [WORD_W:0] eb;
        logic signed [WORD_W:0] s;
        ea = {a[WORD_W-1], a};
        eb = {b[WORD_W-1], b};
        s  = sub ? (ea - eb) : (ea + eb);
        if (s[WORD_W] != s[WORD_W-1])
        begin
            return s[WORD_W] ? W_MIN : W_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    // Full product shifted right by FRAC, truncated toward zero, saturated to one word.
    function automatic word_t mul_q(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] m;
        logic [SHR_W-1:0]  s;
        word_t             r;
        m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        s = m[PROD_W-1:FRAC];
        r = s[WORD_W-1:0];
        if (!p[PROD_W-1])
        begin
            if (s > SHR_W'(W_MAX))
            begin
                return W_MAX;
            end
            return r;
        end
        if (s > SHR_W'(W_MIN))
        begin
            return W_MIN;
        end
        return -r;
    endfunction

endpackage

// ===== rtl/core/gak_div.sv =====
// Gain divider: (num * 2^30) / den, truncated toward zero, magnitude capped at 2^31-1.
// Restoring division, one quotient bit per cycle. Uses gak_pkg.
module gak_div
    import gak_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t num,
    input  word_t den,
    output logic  done,
    output word_t quot
);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [Q_W-1:0]    rem_reg;
    logic [Q_W-1:0]    den_reg;
    logic [Q_W-1:0]    q_reg;
    logic              lsb_reg;
    logic              neg_reg;
    word_t             quot_reg;

    logic [WORD_W-1:0] num_mag;
    logic              den_bad;
    logic              too_big;
    logic [WORD_W-1:0] r_sh;
    logic              ge;
    logic [WORD_W-1:0] diff;

    always_comb
    begin
        num_mag = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
        den_bad = den[WORD_W-1] || (den == '0);
        // The quotient reaches 2^31 exactly when the numerator is at least twice the divisor.
        too_big = num_mag >= {den[Q_W-1:0], 1'b0};
        r_sh    = {rem_reg, lsb_reg};
        ge      = r_sh >= {1'b0, den_reg};
        diff    = r_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den_bad || too_big)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_mag[WORD_W-1:1];
            lsb_reg <= num_mag[0];
            den_reg <= den[Q_W-1:0];
            neg_reg <= num[WORD_W-1];
            q_reg   <= '0;
            cnt_reg <= CNT_W'(Q_W - 1);
            if (den_bad)
            begin
                quot_reg <= '0;
            end
            else if (num[WORD_W-1])
            begin
                quot_reg <= -word_t'({1'b0, GAIN_MAX});
            end
            else
            begin
                quot_reg <= {1'b0, GAIN_MAX};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[Q_W-1:0] : r_sh[Q_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], ge};
            lsb_reg <= 1'b0;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (fin_reg)
        begin
            quot_reg <= neg_reg ? -word_t'({1'b0, q_reg}) : word_t'({1'b0, q_reg});
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/core/gak_dp.sv =====
// Datapath: scratch memory for the filter state, operand selection, saturating adder,
// fixed-point multiplier, the gain divider and the result register. Uses gak_pkg, gak_div.
module gak_dp
    import gak_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  seq_cmd_t cmd,
    input  cfg_t     cfg,
    input  word_t    measured_angle,
    input  word_t    gyro_rate,
    output dp_stat_t stat,
    output logic     out_valid,
    input  logic     out_stall,
    output word_t    angle_out,
    output word_t    rate_out
);

    word_t                     state_mem [MEM_D];
    word_t                     rd_a_reg;
    word_t                     rd_b_reg;
    word_t                     meas_reg;
    word_t                     gyro_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      out_valid_reg;
    word_t                     angle_out_reg;
    word_t                     rate_out_reg;

    word_t opa;
    word_t opb;
    word_t alu_res;
    word_t wr_data;
    logic  wr_en;
    logic  div_start;
    logic  div_done;
    word_t div_quot;
    logic  out_free;
    logic  out_load;

    always_comb
    begin
        case (cmd.word.src_a)
            SA_MEM:  opa = rd_a_reg;
            SA_GYRO: opa = gyro_reg;
            SA_MEAS: opa = meas_reg;
            SA_QA:   opa = {1'b0, cfg.qa};
            SA_QB:   opa = {1'b0, cfg.qb};
            SA_RN:   opa = {1'b0, cfg.rn};
            SA_ZERO: opa = '0;
            SA_ONE:  opa = ONE_Q;
            default: opa = '0;
        endcase
        case (cmd.word.src_b)
            SB_MEM:  opb = rd_b_reg;
            SB_DT:   opb = {1'b0, cfg.dt};
            SB_ZERO: opb = '0;
            default: opb = '0;
        endcase
    end

    assign alu_res   = sat_addsub(opa, opb, cmd.word.op == OP_SUB);
    assign div_start = cmd.ph_exec && (cmd.word.op == OP_DIV);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = cmd.ph_exec && (cmd.word.op == OP_OUT) && out_free;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = alu_res;
        if (cmd.ph_exec && (cmd.word.op == OP_ADD || cmd.word.op == OP_SUB))
        begin
            wr_en = 1'b1;
        end
        else if (cmd.ph_wb)
        begin
            wr_en   = 1'b1;
            wr_data = mul_q(prod_reg);
        end
        else if (cmd.ph_wait && div_done)
        begin
            wr_en   = 1'b1;
            wr_data = div_quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[cmd.word.dst] <= wr_data;
        end
        if (cmd.ph_read)
        begin
            rd_a_reg <= state_mem[cmd.word.addr_a];
            rd_b_reg <= state_mem[cmd.word.addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            meas_reg <= measured_angle;
            gyro_reg <= gyro_rate;
        end
        if (cmd.ph_exec)
        begin
            prod_reg <= PROD_W'(opa) * PROD_W'(opb);
        end
        if (out_load)
        begin
            angle_out_reg <= opa;
            rate_out_reg  <= opb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    gak_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign stat.div_done = div_done;
    assign stat.out_free = out_free;
    assign out_valid     = out_valid_reg;
    assign angle_out     = angle_out_reg;
    assign rate_out      = rate_out_reg;

endmodule

// ===== rtl/core/gak_seq.sv =====
// Microcode sequencer: step counter, microcode table lookup and the phase of each step.
// Each step reads its operands, executes, and writes back when the unit needs it. Uses gak_pkg.
module gak_seq
    import gak_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output seq_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          word;

    assign word = rom_word(pc_reg);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pc_next    = PC_ITEM;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = (word.op == OP_END) ? ST_IDLE : ST_EXEC;
            end
            ST_EXEC:
            begin
                case (word.op)
                    OP_MUL:
                    begin
                        state_next = ST_WB;
                    end
                    OP_DIV:
                    begin
                        state_next = ST_WAIT;
                    end
                    OP_OUT:
                    begin
                        // Hold here until the result register can take the new result.
                        if (stat.out_free)
                        begin
                            pc_next    = pc_reg + PC_W'(1);
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_READ;
                    end
                endcase
            end
            ST_WB:
            begin
                pc_next    = pc_reg + PC_W'(1);
                state_next = ST_READ;
            end
            ST_WAIT:
            begin
                if (stat.div_done)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_READ;
            pc_reg    <= PC_INIT;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cmd.word    = word;
    assign cmd.ph_read = (state_reg == ST_READ);
    assign cmd.ph_exec = (state_reg == ST_EXEC);
    assign cmd.ph_wb   = (state_reg == ST_WB);
    assign cmd.ph_wait = (state_reg == ST_WAIT);
    assign cmd.accept  = in_valid && (state_reg == ST_IDLE);

endmodule

// ===== rtl/core/gyro_accel_angle_kalman_top.sv =====
// Top level of the two-state angle Kalman filter (angle and gyro bias).
// Holds the tuning registers and connects the sequencer and the datapath. Uses gak_pkg.
//
// Input channel: in_valid with measured_angle and gyro_rate (signed Q2.30); the block
// raises in_stall while it works, so one request is taken at a time.
// Output channel: out_valid with angle_out and rate_out (signed Q2.30, saturated);
// the receiver holds out_stall high to keep the result in place.
// Each request runs one predict and correct pass of the microcode. A division ends early
// when its gain saturates or the innovation denominator is not positive, and the next
// request is taken once the pass has reached its end step after out_valid rises.
// Most of a pass is spent in the two gain divisions, which produce one quotient bit per
// cycle; an add step reads and executes, and a multiply step also writes back.
// A result waits in its own register, so a stalled receiver blocks the sequencer only
// when the next result is ready to be written; by then the next request is in flight.
// After reset the sequencer runs seven microcode steps, writing the initial
// state (zero angle and bias, unit covariance diagonal) with in_stall high. Tuning
// registers are written through cfg_we/cfg_index/cfg_data at any time, reset to their
// defaults, and should only change while the filter is idle. Unknown indexes are ignored.
module gyro_accel_angle_kalman_top
    import gak_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  word_t             measured_angle,
    input  word_t             gyro_rate,
    output logic              out_valid,
    input  logic              out_stall,
    output word_t             angle_out,
    output word_t             rate_out,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0] qa_reg;
    logic [CFG_W-1:0] qb_reg;
    logic [CFG_W-1:0] rn_reg;
    logic [CFG_W-1:0] dt_reg;
    cfg_t             cfg;
    seq_cmd_t         cmd;
    dp_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= QA_RST;
            qb_reg <= QB_RST;
            rn_reg <= RN_RST;
            dt_reg <= DT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QA:  qa_reg <= cfg_data;
                CFG_QB:  qb_reg <= cfg_data;
                CFG_RN:  rn_reg <= cfg_data;
                CFG_DT:  dt_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.qa = qa_reg;
    assign cfg.qb = qb_reg;
    assign cfg.rn = rn_reg;
    assign cfg.dt = dt_reg;

    gak_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    gak_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_out      (angle_out),
        .rate_out       (rate_out)
    );

endmodule
